[rtl/core/pbw_pkg.sv]
// ----------------------------------------------------------------------------
// pbw_pkg
// Shared types, register offsets and decode helper for the bridge window
// register file.
// ----------------------------------------------------------------------------
package pbw_pkg;

    localparam int OUT_WINDOWS  = 3;
    localparam int IN_WINDOWS   = 3;
    localparam int HEADER_WORDS = 16;
    localparam int HDR_IDX_W    = $clog2(HEADER_WORDS);

    localparam logic [63:0] IN_ATTR_RESET  = 64'hffff_ffff_0000_0000;
    localparam logic [31:0] OUT_ATTR_MASK  = 32'hffff_fffe;
    localparam logic [63:0] IN_ATTR_MASK   = ~64'h7;
    localparam logic [31:0] CA_ADDR_MASK   = 32'hffff_fffc;
    localparam logic [31:0] CA_ENABLE_BIT  = 32'h8000_0000;
    localparam logic [31:0] SIZE_SATURATE  = 32'hffff_ffff;
    localparam logic [3:0]  CA_WRITE_BYTES = 4'd4;
    localparam logic [7:0]  CA_OFFSET      = 8'h00;

    // register window offsets
    localparam logic [7:0] HDR_LIMIT    = 8'h40;
    localparam logic [7:0] OFF_OLOC_L0  = 8'h68;
    localparam logic [7:0] OFF_OLOC_H0  = 8'h6c;
    localparam logic [7:0] OFF_OATTR0   = 8'h70;
    localparam logic [7:0] OFF_OPCI_L0  = 8'h74;
    localparam logic [7:0] OFF_OPCI_H0  = 8'h78;
    localparam logic [7:0] OFF_OLOC_L1  = 8'h7c;
    localparam logic [7:0] OFF_OLOC_H1  = 8'h80;
    localparam logic [7:0] OFF_OATTR1   = 8'h84;
    localparam logic [7:0] OFF_OPCI_L1  = 8'h88;
    localparam logic [7:0] OFF_OPCI_H1  = 8'h8c;
    localparam logic [7:0] OFF_OATTR2   = 8'h90;
    localparam logic [7:0] OFF_IATTR_L0 = 8'h98;
    localparam logic [7:0] OFF_ILOC_L0  = 8'h9c;
    localparam logic [7:0] OFF_ILOC_H0  = 8'ha0;
    localparam logic [7:0] OFF_IATTR_W1 = 8'ha4;
    localparam logic [7:0] OFF_ILOC_L1  = 8'ha8;
    localparam logic [7:0] OFF_ILOC_H1  = 8'hac;
    localparam logic [7:0] OFF_IATTR_L2 = 8'hb0;
    localparam logic [7:0] OFF_ILOC_L2  = 8'hb4;
    localparam logic [7:0] OFF_ILOC_H2  = 8'hb8;
    localparam logic [7:0] OFF_STATUS   = 8'he0;
    localparam logic [7:0] OFF_IATTR_H0 = 8'hf8;
    localparam logic [7:0] OFF_IATTR_H2 = 8'hfc;

    localparam logic [1:0] WIN0 = 2'd0;
    localparam logic [1:0] WIN1 = 2'd1;
    localparam logic [1:0] WIN2 = 2'd2;

    typedef enum logic [1:0] {
        OP_REG_READ  = 2'd0,
        OP_REG_WRITE = 2'd1,
        OP_CA_READ   = 2'd2,
        OP_CA_WRITE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REMAP_NONE = 2'd0,
        REMAP_OUT  = 2'd1,
        REMAP_IN   = 2'd2
    } remap_kind_t;

    typedef enum logic [3:0] {
        F_NONE,
        F_HEADER,
        F_STATUS,
        F_OLOC_L,
        F_OLOC_H,
        F_OATTR,
        F_OPCI_L,
        F_OPCI_H,
        F_IATTR_L,
        F_IATTR_H,
        F_IATTR_W,
        F_ILOC_L,
        F_ILOC_H
    } field_t;

    typedef struct packed {
        field_t     field;
        logic [1:0] win;
    } decode_t;

    // offset to register field and window number
    function automatic decode_t decode_offset(input logic [7:0] off);
        decode_t d;
        d.field = F_NONE;
        d.win   = WIN0;
        if (off < HDR_LIMIT) begin
            d.field = F_HEADER;
        end else begin
            case (off)
                OFF_OLOC_L0:  d.field = F_OLOC_L;
                OFF_OLOC_H0:  d.field = F_OLOC_H;
                OFF_OATTR0:   d.field = F_OATTR;
                OFF_OPCI_L0:  d.field = F_OPCI_L;
                OFF_OPCI_H0:  d.field = F_OPCI_H;
                OFF_OLOC_L1:  begin d.field = F_OLOC_L;  d.win = WIN1; end
                OFF_OLOC_H1:  begin d.field = F_OLOC_H;  d.win = WIN1; end
                OFF_OATTR1:   begin d.field = F_OATTR;   d.win = WIN1; end
                OFF_OPCI_L1:  begin d.field = F_OPCI_L;  d.win = WIN1; end
                OFF_OPCI_H1:  begin d.field = F_OPCI_H;  d.win = WIN1; end
                OFF_OATTR2:   begin d.field = F_OATTR;   d.win = WIN2; end
                OFF_IATTR_L0: d.field = F_IATTR_L;
                OFF_ILOC_L0:  d.field = F_ILOC_L;
                OFF_ILOC_H0:  d.field = F_ILOC_H;
                OFF_IATTR_W1: begin d.field = F_IATTR_W; d.win = WIN1; end
                OFF_ILOC_L1:  begin d.field = F_ILOC_L;  d.win = WIN1; end
                OFF_ILOC_H1:  begin d.field = F_ILOC_H;  d.win = WIN1; end
                OFF_IATTR_L2: begin d.field = F_IATTR_L; d.win = WIN2; end
                OFF_ILOC_L2:  begin d.field = F_ILOC_L;  d.win = WIN2; end
                OFF_ILOC_H2:  begin d.field = F_ILOC_H;  d.win = WIN2; end
                OFF_STATUS:   d.field = F_STATUS;
                OFF_IATTR_H0: d.field = F_IATTR_H;
                OFF_IATTR_H2: begin d.field = F_IATTR_H; d.win = WIN2; end
                default:      d.field = F_NONE;
            endcase
        end
        return d;
    endfunction

endpackage

[rtl/core/pcix_bridge_window_registers_unit.sv]
// Timing: a request passes the input register and then the result register; m_tvalid
// rises when its result is loaded into the result register.
// Throughput: one request per cycle; the decode, the register update and the window
// size negate all fit between the two registers. s_tready drops only while a stalled
// result and a waiting request fill both registers.
// Reset: aresetn (synchronous, active low) clears both valid flags and sets
// every window, status, header and config-address register to its reset value.
// ----------------------------------------------------------------------------
// pcix_bridge_window_registers_unit
// Register file of a PCI-X host bridge: header mirror, outbound and inbound
// window registers, status word and config-address register, with window
// change reporting on writes.
// ----------------------------------------------------------------------------
module pcix_bridge_window_registers_unit
    import pbw_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // [7:0] register_offset, [39:8] write_data, [43:40] access_bytes
    input  logic [47:0]  s_tdata,
    // [1:0] operation
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [31:0] read_data, [33:32] remap_index, [34] remap_enabled,
    // [98:35] remap_base, [162:99] remap_target, [226:163] remap_size
    output logic [231:0] m_tdata,
    // [0] unhandled, [2:1] remap_kind
    output logic [2:0]   m_tuser
);

    // input register
    logic        in_valid_reg;
    op_t         op_reg;
    logic [7:0]  off_reg;
    logic [31:0] data_reg;
    logic [3:0]  len_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] rd_reg;
    logic        unh_reg;
    remap_kind_t kind_reg;
    logic [1:0]  idx_reg;
    logic        en_reg;
    logic [63:0] base_reg;
    logic [63:0] target_reg;
    logic [63:0] size_reg;

    // architectural state
    logic [63:0] out_local_base_reg [OUT_WINDOWS];
    logic [63:0] out_local_base_next[OUT_WINDOWS];
    logic [63:0] out_pci_base_reg   [OUT_WINDOWS];
    logic [63:0] out_pci_base_next  [OUT_WINDOWS];
    logic [31:0] out_size_attr_reg  [OUT_WINDOWS];
    logic [31:0] out_size_attr_next [OUT_WINDOWS];
    logic [63:0] in_size_attr_reg   [IN_WINDOWS];
    logic [63:0] in_size_attr_next  [IN_WINDOWS];
    logic [63:0] in_local_base_reg  [IN_WINDOWS];
    logic [63:0] in_local_base_next [IN_WINDOWS];
    logic [31:0] status_word_reg;
    logic [31:0] status_word_next;
    logic [31:0] config_header_reg  [HEADER_WORDS];
    logic [31:0] config_header_next [HEADER_WORDS];
    logic [31:0] config_address_reg;
    logic [31:0] config_address_next;

    logic          advance;
    decode_t       dec;
    logic [HDR_IDX_W-1:0] hdr_idx;
    logic [31:0]   rd;
    logic          unh;
    remap_kind_t   kind;
    logic [1:0]    idx;
    logic          en;
    logic [63:0]   base;
    logic [63:0]   target;
    logic [63:0]   size;
    logic [31:0]   out_size;

    // handshake: stage 1 moves on when the result register is free
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign dec     = decode_offset(off_reg);
    assign hdr_idx = off_reg[HDR_IDX_W+1:2];

    // decode, register read/write and window report
    always_comb begin
        out_local_base_next = out_local_base_reg;
        out_pci_base_next   = out_pci_base_reg;
        out_size_attr_next  = out_size_attr_reg;
        in_size_attr_next   = in_size_attr_reg;
        in_local_base_next  = in_local_base_reg;
        status_word_next    = status_word_reg;
        config_header_next  = config_header_reg;
        config_address_next = config_address_reg;
        rd       = '0;
        unh      = 1'b0;
        kind     = REMAP_NONE;
        idx      = '0;
        en       = 1'b0;
        base     = '0;
        target   = '0;
        size     = '0;
        out_size = '0;

        case (op_reg)
            OP_CA_READ: begin
                rd = config_address_reg;
            end
            OP_CA_WRITE: begin
                if (advance && off_reg == CA_OFFSET && len_reg == CA_WRITE_BYTES) begin
                    config_address_next = (data_reg & CA_ADDR_MASK) | CA_ENABLE_BIT;
                end
            end
            OP_REG_READ: begin
                case (dec.field)
                    F_HEADER:  rd = config_header_reg[hdr_idx];
                    F_STATUS:  rd = status_word_reg;
                    F_OLOC_L:  rd = out_local_base_reg[dec.win][31:0];
                    F_OLOC_H:  rd = out_local_base_reg[dec.win][63:32];
                    F_OATTR:   rd = out_size_attr_reg[dec.win];
                    F_OPCI_L:  rd = out_pci_base_reg[dec.win][31:0];
                    F_OPCI_H:  rd = out_pci_base_reg[dec.win][63:32];
                    F_IATTR_L,
                    F_IATTR_W: rd = in_size_attr_reg[dec.win][31:0];
                    F_IATTR_H: rd = in_size_attr_reg[dec.win][63:32];
                    F_ILOC_L:  rd = in_local_base_reg[dec.win][31:0];
                    F_ILOC_H:  rd = in_local_base_reg[dec.win][63:32];
                    default:   unh = 1'b1;
                endcase
            end
            OP_REG_WRITE: begin
                // register update, committed only when the request advances
                case (dec.field)
                    F_HEADER: begin
                        if (advance) config_header_next[hdr_idx] = data_reg;
                    end
                    F_STATUS: begin
                        if (advance) status_word_next = data_reg;
                    end
                    F_OLOC_L: begin
                        out_local_base_next[dec.win][31:0] = data_reg;
                        kind = REMAP_OUT;
                    end
                    F_OLOC_H: begin
                        out_local_base_next[dec.win][63:32] = data_reg;
                        kind = REMAP_OUT;
                    end
                    F_OATTR: begin
                        out_size_attr_next[dec.win] = data_reg;
                        // window 2 attribute write leaves the window unreported
                        if (dec.win != WIN2) kind = REMAP_OUT;
                    end
                    F_OPCI_L: begin
                        out_pci_base_next[dec.win][31:0] = data_reg;
                        kind = REMAP_OUT;
                    end
                    F_OPCI_H: begin
                        out_pci_base_next[dec.win][63:32] = data_reg;
                        kind = REMAP_OUT;
                    end
                    F_IATTR_L: begin
                        in_size_attr_next[dec.win][31:0] = data_reg;
                        kind = REMAP_IN;
                    end
                    F_IATTR_H: begin
                        in_size_attr_next[dec.win][63:32] = data_reg;
                        kind = REMAP_IN;
                    end
                    F_IATTR_W: begin
                        in_size_attr_next[dec.win] = {32'h0, data_reg};
                        kind = REMAP_IN;
                    end
                    F_ILOC_L: begin
                        in_local_base_next[dec.win][31:0] = data_reg;
                        kind = REMAP_IN;
                    end
                    F_ILOC_H: begin
                        in_local_base_next[dec.win][63:32] = data_reg;
                        kind = REMAP_IN;
                    end
                    default: unh = 1'b1;
                endcase

                // window report from the updated values
                case (kind)
                    REMAP_OUT: begin
                        out_size = (~(out_size_attr_next[dec.win] & OUT_ATTR_MASK)) + 32'd1;
                        idx      = dec.win;
                        en       = out_size_attr_next[dec.win][0];
                        base     = out_local_base_next[dec.win];
                        target   = out_pci_base_next[dec.win];
                        size     = {32'h0, (out_size == 32'h0) ? SIZE_SATURATE : out_size};
                    end
                    REMAP_IN: begin
                        idx    = dec.win;
                        en     = in_size_attr_next[dec.win][0];
                        target = in_local_base_next[dec.win];
                        size   = (~(in_size_attr_next[dec.win] & IN_ATTR_MASK)) + 64'd1;
                    end
                    default: begin
                        idx = '0;
                    end
                endcase

                // window registers hold unless the request advances
                if (!advance) begin
                    out_local_base_next = out_local_base_reg;
                    out_pci_base_next   = out_pci_base_reg;
                    out_size_attr_next  = out_size_attr_reg;
                    in_size_attr_next   = in_size_attr_reg;
                    in_local_base_next  = in_local_base_reg;
                end
            end
            default: begin
                rd = '0;
            end
        endcase
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            op_reg   <= op_t'(s_tuser);
            off_reg  <= s_tdata[7:0];
            data_reg <= s_tdata[39:8];
            len_reg  <= s_tdata[43:40];
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= advance || (out_valid_reg && !m_tready);
        end
        if (advance) begin
            rd_reg     <= rd;
            unh_reg    <= unh;
            kind_reg   <= kind;
            idx_reg    <= idx;
            en_reg     <= en;
            base_reg   <= base;
            target_reg <= target;
            size_reg   <= size;
        end
    end

    // architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < OUT_WINDOWS; i++) begin
                out_local_base_reg[i] <= '0;
                out_pci_base_reg[i]   <= '0;
                out_size_attr_reg[i]  <= '0;
            end
            for (int i = 0; i < IN_WINDOWS; i++) begin
                in_size_attr_reg[i]  <= IN_ATTR_RESET;
                in_local_base_reg[i] <= '0;
            end
            for (int i = 0; i < HEADER_WORDS; i++) begin
                config_header_reg[i] <= '0;
            end
            status_word_reg    <= '0;
            config_address_reg <= '0;
        end else begin
            out_local_base_reg <= out_local_base_next;
            out_pci_base_reg   <= out_pci_base_next;
            out_size_attr_reg  <= out_size_attr_next;
            in_size_attr_reg   <= in_size_attr_next;
            in_local_base_reg  <= in_local_base_next;
            config_header_reg  <= config_header_next;
            status_word_reg    <= status_word_next;
            config_address_reg <= config_address_next;
        end
    end

    // result channel packing
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'h0, size_reg, target_reg, base_reg, en_reg, idx_reg, rd_reg};
    assign m_tuser  = {kind_reg, unh_reg};

endmodule

[test/pcix_bridge_window_registers_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcix_bridge_window_registers_unit_tb
// Self-checking bench for the bridge window register file. Register and
// config-address requests are streamed in with random gaps and sink stalls.
// A predictor class keeps its own copy of every register, works out the read
// value and the window change report for each request, and checks each
// result against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module pcix_bridge_window_registers_unit_tb;
    import pbw_pkg::*;

    localparam int RESET_CYCLES     = 7;
    localparam int RANDOM_REQUESTS  = 1700;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int STALL_LIMIT      = 2000;
    localparam int TAIL_CYCLES      = 8;

    localparam logic [7:0] HDR_FIRST  = 8'h00;
    localparam logic [7:0] OFF_UNUSED = 8'hf4;

    // one expected result
    typedef struct {
        logic [31:0] read_data;
        logic        unhandled;
        remap_kind_t kind;
        logic [1:0]  index;
        logic        enabled;
        logic [63:0] base;
        logic [63:0] target;
        logic [63:0] size;
    } access_result_t;

    // ------------------------------------------------------------------------
    // predictor of the register file and store of expected results
    // ------------------------------------------------------------------------
    class bridge_regs_predictor;
        logic [63:0]    ob_local [OUT_WINDOWS];
        logic [63:0]    ob_pci [OUT_WINDOWS];
        logic [31:0]    ob_attr [OUT_WINDOWS];
        logic [63:0]    ib_attr [IN_WINDOWS];
        logic [63:0]    ib_local [IN_WINDOWS];
        logic [31:0]    status_reg;
        logic [31:0]    hdr_words [HEADER_WORDS];
        logic [31:0]    cfg_addr;
        access_result_t pending [$];
        int             mismatches;
        int             results_seen;

        function new();
            for (int i = 0; i < OUT_WINDOWS; i++) begin
                ob_local[i] = '0;
                ob_pci[i]   = '0;
                ob_attr[i]  = '0;
            end
            for (int i = 0; i < IN_WINDOWS; i++) begin
                ib_attr[i]  = IN_ATTR_RESET;
                ib_local[i] = '0;
            end
            for (int i = 0; i < HEADER_WORDS; i++) hdr_words[i] = '0;
            status_reg   = '0;
            cfg_addr     = '0;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function int outstanding();
            return pending.size();
        endfunction

        // register offset to field and window
        function void locate(input logic [7:0] off, output field_t f, output logic [1:0] w);
            w = WIN0;
            f = F_NONE;
            if (off < HDR_LIMIT) begin
                f = F_HEADER;
            end else begin
                case (off)
                    OFF_OLOC_L0:  f = F_OLOC_L;
                    OFF_OLOC_H0:  f = F_OLOC_H;
                    OFF_OATTR0:   f = F_OATTR;
                    OFF_OPCI_L0:  f = F_OPCI_L;
                    OFF_OPCI_H0:  f = F_OPCI_H;
                    OFF_OLOC_L1:  begin f = F_OLOC_L;  w = WIN1; end
                    OFF_OLOC_H1:  begin f = F_OLOC_H;  w = WIN1; end
                    OFF_OATTR1:   begin f = F_OATTR;   w = WIN1; end
                    OFF_OPCI_L1:  begin f = F_OPCI_L;  w = WIN1; end
                    OFF_OPCI_H1:  begin f = F_OPCI_H;  w = WIN1; end
                    OFF_OATTR2:   begin f = F_OATTR;   w = WIN2; end
                    OFF_IATTR_L0: f = F_IATTR_L;
                    OFF_ILOC_L0:  f = F_ILOC_L;
                    OFF_ILOC_H0:  f = F_ILOC_H;
                    OFF_IATTR_W1: begin f = F_IATTR_W; w = WIN1; end
                    OFF_ILOC_L1:  begin f = F_ILOC_L;  w = WIN1; end
                    OFF_ILOC_H1:  begin f = F_ILOC_H;  w = WIN1; end
                    OFF_IATTR_L2: begin f = F_IATTR_L; w = WIN2; end
                    OFF_ILOC_L2:  begin f = F_ILOC_L;  w = WIN2; end
                    OFF_ILOC_H2:  begin f = F_ILOC_H;  w = WIN2; end
                    OFF_STATUS:   f = F_STATUS;
                    OFF_IATTR_H0: f = F_IATTR_H;
                    OFF_IATTR_H2: begin f = F_IATTR_H; w = WIN2; end
                    default:      f = F_NONE;
                endcase
            end
        endfunction

        function logic [63:0] put_half(logic [63:0] old, logic [31:0] v, logic hi);
            return hi ? {v, old[31:0]} : {old[63:32], v};
        endfunction

        // predict the result of one accepted request
        function void note_request(op_t op, logic [7:0] off, logic [31:0] wdata,
                                   logic [3:0] nbytes);
            access_result_t r;
            field_t         f;
            logic [1:0]     w;
            logic [31:0]    osz;
            r.read_data = '0;
            r.unhandled = 1'b0;
            r.kind      = REMAP_NONE;
            r.index     = '0;
            r.enabled   = 1'b0;
            r.base      = '0;
            r.target    = '0;
            r.size      = '0;
            locate(off, f, w);
            case (op)
                OP_CA_READ: r.read_data = cfg_addr;
                OP_CA_WRITE: begin
                    if (off == CA_OFFSET && nbytes == CA_WRITE_BYTES)
                        cfg_addr = (wdata & CA_ADDR_MASK) | CA_ENABLE_BIT;
                end
                OP_REG_READ: begin
                    case (f)
                        F_HEADER:             r.read_data = hdr_words[off[5:2]];
                        F_STATUS:             r.read_data = status_reg;
                        F_OLOC_L:             r.read_data = ob_local[w][31:0];
                        F_OLOC_H:             r.read_data = ob_local[w][63:32];
                        F_OATTR:              r.read_data = ob_attr[w];
                        F_OPCI_L:             r.read_data = ob_pci[w][31:0];
                        F_OPCI_H:             r.read_data = ob_pci[w][63:32];
                        F_IATTR_L, F_IATTR_W: r.read_data = ib_attr[w][31:0];
                        F_IATTR_H:            r.read_data = ib_attr[w][63:32];
                        F_ILOC_L:             r.read_data = ib_local[w][31:0];
                        F_ILOC_H:             r.read_data = ib_local[w][63:32];
                        default:              r.unhandled = 1'b1;
                    endcase
                end
                default: begin
                    case (f)
                        F_HEADER: hdr_words[off[5:2]] = wdata;
                        F_STATUS: status_reg = wdata;
                        F_OLOC_L, F_OLOC_H: begin
                            ob_local[w] = put_half(ob_local[w], wdata, f == F_OLOC_H);
                            r.kind = REMAP_OUT;
                        end
                        F_OATTR: begin
                            // window 2 attribute is stored but never reported
                            ob_attr[w] = wdata;
                            if (w != WIN2) r.kind = REMAP_OUT;
                        end
                        F_OPCI_L, F_OPCI_H: begin
                            ob_pci[w] = put_half(ob_pci[w], wdata, f == F_OPCI_H);
                            r.kind = REMAP_OUT;
                        end
                        F_IATTR_L, F_IATTR_H: begin
                            ib_attr[w] = put_half(ib_attr[w], wdata, f == F_IATTR_H);
                            r.kind = REMAP_IN;
                        end
                        F_IATTR_W: begin
                            // whole attribute replaced by the zero-extended word
                            ib_attr[w] = {32'h0, wdata};
                            r.kind = REMAP_IN;
                        end
                        F_ILOC_L, F_ILOC_H: begin
                            ib_local[w] = put_half(ib_local[w], wdata, f == F_ILOC_H);
                            r.kind = REMAP_IN;
                        end
                        default: r.unhandled = 1'b1;
                    endcase
                    // window change report
                    if (r.kind == REMAP_OUT) begin
                        osz = ~(ob_attr[w] & OUT_ATTR_MASK) + 32'd1;
                        if (osz == '0) osz = SIZE_SATURATE;
                        r.index   = w;
                        r.enabled = ob_attr[w][0];
                        r.base    = ob_local[w];
                        r.target  = ob_pci[w];
                        r.size    = {32'h0, osz};
                    end else if (r.kind == REMAP_IN) begin
                        r.index   = w;
                        r.enabled = ib_attr[w][0];
                        r.target  = ib_local[w];
                        r.size    = ~(ib_attr[w] & IN_ATTR_MASK) + 64'd1;
                    end
                end
            endcase
            pending.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: %s expected %h got %h", results_seen, name, want, got);
            end
        endfunction

        // compare one accepted result with the oldest prediction
        function void check_result(logic [231:0] td, logic [2:0] tu);
            access_result_t want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result %0d: no request outstanding, data %h user %h",
                             results_seen, td, tu);
                return;
            end
            want = pending.pop_front();
            check_field("read_data", 64'(want.read_data), 64'(td[31:0]));
            check_field("unhandled", 64'(want.unhandled), 64'(tu[0]));
            check_field("remap_kind", 64'(want.kind), 64'(tu[2:1]));
            check_field("remap_index", 64'(want.index), 64'(td[33:32]));
            check_field("remap_enabled", 64'(want.enabled), 64'(td[34]));
            check_field("remap_base", want.base, td[98:35]);
            check_field("remap_target", want.target, td[162:99]);
            check_field("remap_size", want.size, td[226:163]);
        endfunction
    endclass

    logic         aclk = 1'b0;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [47:0]  s_tdata;
    logic [1:0]   s_tuser;
    logic         m_tvalid;
    logic         m_tready;
    logic [231:0] m_tdata;
    logic [2:0]   m_tuser;

    bit sink_hold_req;
    bit no_idle;
    int idle_cycles = 0;

    bridge_regs_predictor regs_pred = new();

    logic [7:0] known_offsets [23] = '{
        OFF_OLOC_L0, OFF_OLOC_H0, OFF_OATTR0, OFF_OPCI_L0, OFF_OPCI_H0,
        OFF_OLOC_L1, OFF_OLOC_H1, OFF_OATTR1, OFF_OPCI_L1, OFF_OPCI_H1,
        OFF_OATTR2, OFF_IATTR_L0, OFF_ILOC_L0, OFF_ILOC_H0, OFF_IATTR_W1,
        OFF_ILOC_L1, OFF_ILOC_H1, OFF_IATTR_L2, OFF_ILOC_L2, OFF_ILOC_H2,
        OFF_STATUS, OFF_IATTR_H0, OFF_IATTR_H2
    };

    pcix_bridge_window_registers_unit uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [31:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hffff_ffff;
        if (r == 2) return 32'($urandom_range(0, 15));
        if (r == 3) return ~32'($urandom_range(0, 15));
        return $urandom;
    endfunction

    // result check on every accepted result
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            regs_pred.check_result(m_tdata, m_tuser);
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("pcix_bridge_window_registers_unit_tb NOT OK");
            $finish;
        end
    end

    // result sink with random stalls and one long hold-off
    initial begin : sink_side
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge aclk);
            if (sink_hold_req) begin
                m_tready = 1'b0;
                repeat (SINK_HOLD_CYCLES - 1) @(negedge aclk);
                sink_hold_req = 1'b0;
                m_tready = 1'b1;
            end else if (no_idle) begin
                m_tready = 1'b1;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
            end
        end
    end

    // offer one request, wait for the handshake, then idle for a while
    task automatic issue(op_t op, logic [7:0] off, logic [31:0] wdata, logic [3:0] nbytes);
        int gap;
        s_tuser  = op;
        s_tdata  = {4'h0, nbytes, wdata, off};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        regs_pred.note_request(op, off, wdata, nbytes);
        @(negedge aclk);
        gap = no_idle ? 0 : pick_gap();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (regs_pred.outstanding() != 0) @(negedge aclk);
    endtask

    // random request, mostly to decoded registers
    task automatic random_request();
        int          r;
        op_t         op;
        logic [7:0]  off;
        logic [3:0]  nbytes;
        r = $urandom_range(0, 99);
        if (r < 35) op = OP_REG_READ;
        else if (r < 80) op = OP_REG_WRITE;
        else if (r < 88) op = OP_CA_READ;
        else op = OP_CA_WRITE;
        r = $urandom_range(0, 99);
        if (op == OP_CA_WRITE && r < 50) off = CA_OFFSET;
        else if (r < 70) off = known_offsets[$urandom_range(0, 22)];
        else if (r < 85) off = 8'($urandom_range(0, 63));
        else off = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 50) nbytes = CA_WRITE_BYTES;
        else nbytes = 4'($urandom_range(1, 8));
        issue(op, off, pick_data(), nbytes);
    endtask

    initial begin
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tuser       = OP_REG_READ;
        m_tready      = 1'b0;
        sink_hold_req = 1'b0;
        no_idle       = 1'b0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;

        // reset values of inbound attributes
        issue(OP_REG_READ,  OFF_IATTR_H0, 32'h0, 4'd4);
        issue(OP_REG_READ,  OFF_IATTR_L2, 32'h0, 4'd4);
        // header extremes and unaligned header offsets
        issue(OP_REG_WRITE, HDR_FIRST, 32'hffff_ffff, 4'd1);
        issue(OP_REG_WRITE, HDR_LIMIT - 8'd4, 32'h8000_0001, 4'd8);
        issue(OP_REG_READ,  HDR_LIMIT - 8'd1, 32'h0, 4'd4);
        issue(OP_REG_READ,  HDR_FIRST + 8'd2, 32'h0, 4'd4);
        // outbound window 0: full local base, zero attribute saturates the size
        issue(OP_REG_WRITE, OFF_OLOC_L0, 32'hffff_ffff, 4'd4);
        issue(OP_REG_WRITE, OFF_OLOC_H0, 32'hffff_ffff, 4'd4);
        issue(OP_REG_WRITE, OFF_OPCI_H0, 32'h8000_0000, 4'd4);
        issue(OP_REG_WRITE, OFF_OATTR0, 32'h0, 4'd4);
        // outbound window 1 enabled with the smallest size
        issue(OP_REG_WRITE, OFF_OATTR1, 32'hffff_ffff, 4'd4);
        issue(OP_REG_WRITE, OFF_OPCI_L1, 32'h1234_5678, 4'd4);
        issue(OP_REG_READ,  OFF_OPCI_L1, 32'h0, 4'd4);
        // window 2 attribute stored without a report
        issue(OP_REG_WRITE, OFF_OATTR2, 32'hfff0_0001, 4'd4);
        issue(OP_REG_READ,  OFF_OATTR2, 32'h0, 4'd4);
        // inbound: whole-word attribute, halves, local bases
        issue(OP_REG_WRITE, OFF_IATTR_W1, 32'hffff_fff9, 4'd4);
        issue(OP_REG_READ,  OFF_IATTR_W1, 32'h0, 4'd4);
        issue(OP_REG_WRITE, OFF_IATTR_H2, 32'h0, 4'd4);
        issue(OP_REG_WRITE, OFF_IATTR_L0, 32'hffff_ffff, 4'd4);
        issue(OP_REG_WRITE, OFF_ILOC_H2, 32'hffff_ffff, 4'd4);
        issue(OP_REG_WRITE, OFF_STATUS, 32'hdead_beef, 4'd4);
        issue(OP_REG_READ,  OFF_STATUS, 32'h0, 4'd4);
        // unaligned window offset and unknown offsets
        issue(OP_REG_READ,  OFF_OLOC_L0 + 8'd1, 32'h0, 4'd4);
        issue(OP_REG_WRITE, OFF_UNUSED, 32'hffff_ffff, 4'd4);
        issue(OP_REG_READ,  OFF_IATTR_H2 + 8'd3, 32'h0, 4'd4);
        // config-address: accepted write, wrong offset, wrong lengths
        issue(OP_CA_WRITE,  CA_OFFSET, 32'hffff_ffff, CA_WRITE_BYTES);
        issue(OP_CA_WRITE,  CA_OFFSET + 8'd4, 32'h0, CA_WRITE_BYTES);
        issue(OP_CA_WRITE,  CA_OFFSET, 32'h0, 4'd8);
        issue(OP_CA_READ,   8'haa, 32'h0, 4'd1);

        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n == 400) sink_hold_req = 1'b1;
            if (n == 900) wait_drained();
            no_idle = (n >= 1200 && n < 1350);
            random_request();
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (regs_pred.mismatches == 0 && regs_pred.outstanding() == 0)
            $display("pcix_bridge_window_registers_unit_tb OK");
        else
            $display("pcix_bridge_window_registers_unit_tb NOT OK");
        $finish;
    end

endmodule
